// ----- rtl/gtis_pkg.sv -----
// ---------------------------------------------------------------------------
// gtis_pkg: shared types and arithmetic helpers
// Fixed-point types, saturation and rounding helpers and register indexes
// for the implicit gyroscopic torque step.
// ---------------------------------------------------------------------------
`default_nettype none

package gtis_pkg;

    typedef logic signed [31:0] q_t;
    typedef q_t [2:0]           vec_t;
    typedef q_t [2:0][2:0]      mat_t;
    typedef logic signed [17:0] qc_t;
    typedef qc_t [2:0]          qvec_t;
    typedef logic signed [18:0] rq_t;
    typedef rq_t [2:0]          rvec_t;
    typedef logic signed [32:0] w33_t;
    typedef logic signed [65:0] prod_t;
    typedef prod_t [2:0]        pvec_t;
    typedef prod_t [2:0][2:0]   pmat_t;
    typedef logic signed [35:0] acc_t;

    localparam q_t Q_MAX  = {1'b0, {31{1'b1}}};
    localparam q_t Q_MIN  = {1'b1, {31{1'b0}}};
    localparam int DIV_QB = 33;

    typedef enum logic [2:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_INERTIA_XX = 3'd1,
        CFG_INERTIA_YY = 3'd2,
        CFG_INERTIA_ZZ = 3'd3,
        CFG_INERTIA_XY = 3'd4,
        CFG_INERTIA_XZ = 3'd5,
        CFG_INERTIA_YZ = 3'd6
    } cfg_idx_e;

    typedef struct packed {
        qc_t   s;
        qvec_t r;
        vec_t  w;
    } body_t;

    typedef struct packed {
        body_t body;
        vec_t  v;
    } jside_t;

    typedef struct packed {
        logic  sing;
        body_t body;
        vec_t  v;
    } dside_t;

    typedef struct packed {
        logic  sing;
        body_t body;
    } rside_t;

    typedef struct packed {
        vec_t v;
        logic sing;
    } res_t;

    // next index modulo three
    function automatic int nx(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic q_t sat32(input acc_t x);
        if (x > acc_t'(Q_MAX)) return Q_MAX;
        if (x < acc_t'(Q_MIN)) return Q_MIN;
        return x[31:0];
    endfunction

    function automatic prod_t mul(input w33_t a, input w33_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    // round to nearest, ties up, then saturate
    function automatic q_t rnd(input prod_t p, input int unsigned frac);
        prod_t r;
        r = (p + (prod_t'(1) <<< (frac - 1))) >>> frac;
        if (r > prod_t'(Q_MAX)) return Q_MAX;
        if (r < prod_t'(Q_MIN)) return Q_MIN;
        return r[31:0];
    endfunction

    function automatic w33_t neg33(input q_t x);
        return -w33_t'(x);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gtis_rotate.sv -----
// ---------------------------------------------------------------------------
// gtis_rotate: pipelined quaternion rotation
// Rotates u by (s, r): t = 2 (r x u), u' = u + s t + r x t, in four stages.
// ---------------------------------------------------------------------------
`default_nettype none

module gtis_rotate #(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             ce,
    input  wire logic             in_valid,
    input  gtis_pkg::qc_t         in_s,
    input  gtis_pkg::rvec_t       in_r,
    input  gtis_pkg::vec_t        in_u,
    input  wire logic [SB_W-1:0]  in_sb,
    output logic                  out_valid,
    output gtis_pkg::vec_t        out_o,
    output logic [SB_W-1:0]       out_sb
);

    localparam int NST = 4;

    logic [NST-1:0]    vld_reg;
    gtis_pkg::qc_t     s_reg [0:1];
    gtis_pkg::rvec_t   r_reg [0:1];
    gtis_pkg::vec_t    u_reg [0:2];
    logic [SB_W-1:0]   sb_reg [0:NST-1];
    gtis_pkg::pvec_t   pa_reg, pa_next, pb_reg, pb_next;
    gtis_pkg::vec_t    t_reg, t_next;
    gtis_pkg::pvec_t   ca_reg, ca_next, cb_reg, cb_next, st_reg, st_next;
    gtis_pkg::vec_t    o_reg, o_next;

    // first cross products r x u
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pa_next[k] = gtis_pkg::mul(in_r[gtis_pkg::nx(k)], in_u[gtis_pkg::nx(gtis_pkg::nx(k))]);
            pb_next[k] = gtis_pkg::mul(in_r[gtis_pkg::nx(gtis_pkg::nx(k))], in_u[gtis_pkg::nx(k)]);
        end
    end

    // t = 2 (r x u)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t_next[k] = gtis_pkg::sat32(gtis_pkg::acc_t'(gtis_pkg::sat32(
                gtis_pkg::acc_t'(gtis_pkg::rnd(pa_reg[k], FRAC_BITS))
                - gtis_pkg::acc_t'(gtis_pkg::rnd(pb_reg[k], FRAC_BITS)))) <<< 1);
        end
    end

    // second cross products r x t and s t
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ca_next[k] = gtis_pkg::mul(r_reg[1][gtis_pkg::nx(k)],
                                       t_reg[gtis_pkg::nx(gtis_pkg::nx(k))]);
            cb_next[k] = gtis_pkg::mul(r_reg[1][gtis_pkg::nx(gtis_pkg::nx(k))],
                                       t_reg[gtis_pkg::nx(k)]);
            st_next[k] = gtis_pkg::mul(s_reg[1], t_reg[k]);
        end
    end

    // sum u + s t + r x t
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_next[k] = gtis_pkg::sat32(gtis_pkg::acc_t'(u_reg[2][k])
                + gtis_pkg::acc_t'(gtis_pkg::rnd(st_reg[k], FRAC_BITS))
                + gtis_pkg::acc_t'(gtis_pkg::sat32(
                    gtis_pkg::acc_t'(gtis_pkg::rnd(ca_reg[k], FRAC_BITS))
                    - gtis_pkg::acc_t'(gtis_pkg::rnd(cb_reg[k], FRAC_BITS)))));
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            s_reg[0]  <= in_s;
            r_reg[0]  <= in_r;
            u_reg[0]  <= in_u;
            sb_reg[0] <= in_sb;
            t_reg     <= t_next;
            s_reg[1]  <= s_reg[0];
            r_reg[1]  <= r_reg[0];
            u_reg[1]  <= u_reg[0];
            sb_reg[1] <= sb_reg[0];
            ca_reg    <= ca_next;
            cb_reg    <= cb_next;
            st_reg    <= st_next;
            u_reg[2]  <= u_reg[1];
            sb_reg[2] <= sb_reg[1];
            o_reg     <= o_next;
            sb_reg[3] <= sb_reg[2];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_o     = o_reg;
    assign out_sb    = sb_reg[NST-1];

endmodule

`default_nettype wire

// ----- rtl/gtis_jacob.sv -----
// ---------------------------------------------------------------------------
// gtis_jacob: momentum, residual, Jacobian, cofactors and determinant
// Nine stages from the body-frame velocity to adj(J) f and det(J).
// ---------------------------------------------------------------------------
`default_nettype none

module gtis_jacob #(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             ce,
    input  wire logic [16:0]      time_step,
    input  wire logic [30:0]      inertia_xx,
    input  wire logic [30:0]      inertia_yy,
    input  wire logic [30:0]      inertia_zz,
    input  gtis_pkg::q_t          inertia_xy,
    input  gtis_pkg::q_t          inertia_xz,
    input  gtis_pkg::q_t          inertia_yz,
    input  wire logic             in_valid,
    input  gtis_pkg::vec_t        in_v,
    input  wire logic [SB_W-1:0]  in_sb,
    output logic                  out_valid,
    output gtis_pkg::vec_t        out_n,
    output gtis_pkg::q_t          out_det,
    output logic [SB_W-1:0]       out_sb
);

    localparam int NST = 9;

    logic [NST-1:0]   vld_reg;
    logic [SB_W-1:0]  sb_reg [0:NST-1];
    gtis_pkg::mat_t   im;
    gtis_pkg::w33_t   hh;

    gtis_pkg::pmat_t  lp_reg, lp_next, ga_reg, ga_next, gb_reg, gb_next;
    gtis_pkg::vec_t   v1_reg, v2_reg;
    gtis_pkg::vec_t   l2_reg, l2_next;
    gtis_pkg::mat_t   g2_reg, g2_next;
    gtis_pkg::mat_t   d3_reg, d3_next;
    gtis_pkg::pvec_t  ca3_reg, ca3_next, cb3_reg, cb3_next;
    gtis_pkg::pmat_t  hd4_reg, hd4_next;
    gtis_pkg::vec_t   c4_reg, c4_next;
    gtis_pkg::mat_t   j5_reg, j5_next;
    gtis_pkg::pvec_t  hc5_reg, hc5_next;
    gtis_pkg::vec_t   f6_reg, f6_next, f7_reg;
    gtis_pkg::pmat_t  ka6_reg, ka6_next, kb6_reg, kb6_next;
    gtis_pkg::vec_t   j0_6_reg, j0_7_reg;
    gtis_pkg::mat_t   c7_reg, c7_next;
    gtis_pkg::pvec_t  dp8_reg, dp8_next;
    gtis_pkg::pmat_t  np8_reg, np8_next;
    gtis_pkg::q_t     det_reg, det_next;
    gtis_pkg::vec_t   n_reg, n_next;

    // symmetric inertia and step length
    always_comb begin
        im[0][0] = gtis_pkg::q_t'({1'b0, inertia_xx});
        im[1][1] = gtis_pkg::q_t'({1'b0, inertia_yy});
        im[2][2] = gtis_pkg::q_t'({1'b0, inertia_zz});
        im[0][1] = inertia_xy;
        im[1][0] = inertia_xy;
        im[0][2] = inertia_xz;
        im[2][0] = inertia_xz;
        im[1][2] = inertia_yz;
        im[2][1] = inertia_yz;
        hh       = gtis_pkg::w33_t'({1'b0, time_step});
    end

    // products for L = I v and G = skew(v) I
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                lp_next[i][j] = gtis_pkg::mul(im[i][j], in_v[j]);
                ga_next[i][j] = gtis_pkg::mul(
                    gtis_pkg::neg33(in_v[gtis_pkg::nx(gtis_pkg::nx(i))]),
                    im[gtis_pkg::nx(i)][j]);
                gb_next[i][j] = gtis_pkg::mul(in_v[gtis_pkg::nx(i)],
                                              im[gtis_pkg::nx(gtis_pkg::nx(i))][j]);
            end
        end
    end

    // sum L and G
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            l2_next[i] = gtis_pkg::sat32(gtis_pkg::acc_t'(gtis_pkg::rnd(lp_reg[i][0], FRAC_BITS))
                + gtis_pkg::acc_t'(gtis_pkg::rnd(lp_reg[i][1], FRAC_BITS))
                + gtis_pkg::acc_t'(gtis_pkg::rnd(lp_reg[i][2], FRAC_BITS)));
            for (int j = 0; j < 3; j++) begin
                g2_next[i][j] = gtis_pkg::sat32(
                    gtis_pkg::acc_t'(gtis_pkg::rnd(ga_reg[i][j], FRAC_BITS))
                    + gtis_pkg::acc_t'(gtis_pkg::rnd(gb_reg[i][j], FRAC_BITS)));
            end
        end
    end

    // D = G - skew(L), products for v x L
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d3_next[i][i] = g2_reg[i][i];
            d3_next[i][gtis_pkg::nx(i)] = gtis_pkg::sat32(
                gtis_pkg::acc_t'(g2_reg[i][gtis_pkg::nx(i)])
                + gtis_pkg::acc_t'(l2_reg[gtis_pkg::nx(gtis_pkg::nx(i))]));
            d3_next[i][gtis_pkg::nx(gtis_pkg::nx(i))] = gtis_pkg::sat32(
                gtis_pkg::acc_t'(g2_reg[i][gtis_pkg::nx(gtis_pkg::nx(i))])
                - gtis_pkg::acc_t'(l2_reg[gtis_pkg::nx(i)]));
            ca3_next[i] = gtis_pkg::mul(v2_reg[gtis_pkg::nx(i)],
                                        l2_reg[gtis_pkg::nx(gtis_pkg::nx(i))]);
            cb3_next[i] = gtis_pkg::mul(v2_reg[gtis_pkg::nx(gtis_pkg::nx(i))],
                                        l2_reg[gtis_pkg::nx(i)]);
        end
    end

    // products h D, cross v x L
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c4_next[i] = gtis_pkg::sat32(gtis_pkg::acc_t'(gtis_pkg::rnd(ca3_reg[i], FRAC_BITS))
                - gtis_pkg::acc_t'(gtis_pkg::rnd(cb3_reg[i], FRAC_BITS)));
            for (int j = 0; j < 3; j++) begin
                hd4_next[i][j] = gtis_pkg::mul(hh, d3_reg[i][j]);
            end
        end
    end

    // J = I + h D, products for f = h (v x L)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hc5_next[i] = gtis_pkg::mul(hh, c4_reg[i]);
            for (int j = 0; j < 3; j++) begin
                j5_next[i][j] = gtis_pkg::sat32(gtis_pkg::acc_t'(im[i][j])
                    + gtis_pkg::acc_t'(gtis_pkg::rnd(hd4_reg[i][j], FRAC_BITS)));
            end
        end
    end

    // residual, cofactor products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f6_next[i] = gtis_pkg::rnd(hc5_reg[i], FRAC_BITS);
            for (int j = 0; j < 3; j++) begin
                ka6_next[i][j] = gtis_pkg::mul(
                    j5_reg[gtis_pkg::nx(i)][gtis_pkg::nx(j)],
                    j5_reg[gtis_pkg::nx(gtis_pkg::nx(i))][gtis_pkg::nx(gtis_pkg::nx(j))]);
                kb6_next[i][j] = gtis_pkg::mul(
                    j5_reg[gtis_pkg::nx(i)][gtis_pkg::nx(gtis_pkg::nx(j))],
                    j5_reg[gtis_pkg::nx(gtis_pkg::nx(i))][gtis_pkg::nx(j)]);
            end
        end
    end

    // cofactors
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c7_next[i][j] = gtis_pkg::sat32(
                    gtis_pkg::acc_t'(gtis_pkg::rnd(ka6_reg[i][j], FRAC_BITS))
                    - gtis_pkg::acc_t'(gtis_pkg::rnd(kb6_reg[i][j], FRAC_BITS)));
            end
        end
    end

    // determinant and adj(J) f products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dp8_next[i] = gtis_pkg::mul(j0_7_reg[i], c7_reg[0][i]);
            for (int k = 0; k < 3; k++) begin
                np8_next[i][k] = gtis_pkg::mul(c7_reg[k][i], f7_reg[k]);
            end
        end
    end

    // sum determinant and adj(J) f
    always_comb begin
        det_next = gtis_pkg::sat32(gtis_pkg::acc_t'(gtis_pkg::rnd(dp8_reg[0], FRAC_BITS))
            + gtis_pkg::acc_t'(gtis_pkg::rnd(dp8_reg[1], FRAC_BITS))
            + gtis_pkg::acc_t'(gtis_pkg::rnd(dp8_reg[2], FRAC_BITS)));
        for (int i = 0; i < 3; i++) begin
            n_next[i] = gtis_pkg::sat32(gtis_pkg::acc_t'(gtis_pkg::rnd(np8_reg[i][0], FRAC_BITS))
                + gtis_pkg::acc_t'(gtis_pkg::rnd(np8_reg[i][1], FRAC_BITS))
                + gtis_pkg::acc_t'(gtis_pkg::rnd(np8_reg[i][2], FRAC_BITS)));
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            sb_reg[0] <= in_sb;
            for (int k = 1; k < NST; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
            lp_reg   <= lp_next;
            ga_reg   <= ga_next;
            gb_reg   <= gb_next;
            v1_reg   <= in_v;
            l2_reg   <= l2_next;
            g2_reg   <= g2_next;
            v2_reg   <= v1_reg;
            d3_reg   <= d3_next;
            ca3_reg  <= ca3_next;
            cb3_reg  <= cb3_next;
            hd4_reg  <= hd4_next;
            c4_reg   <= c4_next;
            j5_reg   <= j5_next;
            hc5_reg  <= hc5_next;
            f6_reg   <= f6_next;
            ka6_reg  <= ka6_next;
            kb6_reg  <= kb6_next;
            j0_6_reg <= j5_reg[0];
            c7_reg   <= c7_next;
            f7_reg   <= f6_reg;
            j0_7_reg <= j0_6_reg;
            dp8_reg  <= dp8_next;
            np8_reg  <= np8_next;
            det_reg  <= det_next;
            n_reg    <= n_next;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_n     = n_reg;
    assign out_det   = det_reg;
    assign out_sb    = sb_reg[NST-1];

endmodule

`default_nettype wire

// ----- rtl/gtis_div.sv -----
// ---------------------------------------------------------------------------
// gtis_div: pipelined three-lane fixed-point divider
// Forms sat32((n << FRAC_BITS) / den), truncated toward zero, one quotient
// bit per stage on the magnitudes.
// ---------------------------------------------------------------------------
`default_nettype none

module gtis_div #(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             ce,
    input  wire logic             in_valid,
    input  gtis_pkg::vec_t        in_n,
    input  gtis_pkg::q_t          in_den,
    input  wire logic [SB_W-1:0]  in_sb,
    output logic                  out_valid,
    output gtis_pkg::vec_t        out_x,
    output logic [SB_W-1:0]       out_sb
);

    localparam int QB  = gtis_pkg::DIV_QB;
    localparam int NW  = 32 + FRAC_BITS;
    localparam int CW  = 32 + QB;
    localparam int NST = QB + 2;

    logic [NST-1:0]   vld_reg;
    logic [SB_W-1:0]  sb_reg  [0:NST-1];
    logic [31:0]      dm_reg  [0:QB];
    logic [31:0]      rem_reg [0:QB][0:2];
    logic [QB-1:0]    low_reg [0:QB][0:2];
    logic [QB-1:0]    q_reg   [0:QB][0:2];
    logic [2:0]       neg_reg [0:QB];
    logic [2:0]       ovf_reg [0:QB];
    wire  [2:0]       neg_next;
    wire  [2:0]       ovf_next;
    gtis_pkg::vec_t   x_reg;
    gtis_pkg::w33_t   dx;
    logic [31:0]      dm_next;

    // divisor magnitude
    always_comb begin
        dx      = gtis_pkg::w33_t'(in_den);
        dm_next = dx[32] ? 32'(-dx) : dx[31:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dm_reg[0]  <= dm_next;
            sb_reg[0]  <= in_sb;
            neg_reg[0] <= neg_next;
            ovf_reg[0] <= ovf_next;
            for (int k = 1; k <= QB; k++) begin
                dm_reg[k]  <= dm_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            for (int k = 1; k < NST; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    genvar l, k;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            gtis_pkg::w33_t  nx33;
            logic [31:0]     nm;
            logic [NW-1:0]   big;
            gtis_pkg::q_t    x_next;
            logic [QB-1:0]   qf;

            // magnitudes, overflow check and first remainder
            always_comb begin
                nx33 = gtis_pkg::w33_t'(in_n[l]);
                nm   = nx33[32] ? 32'(-nx33) : nx33[31:0];
                big  = {nm, {FRAC_BITS{1'b0}}};
            end

            assign neg_next[l] = in_n[l][31] ^ in_den[31];
            assign ovf_next[l] = {{(CW - NW){1'b0}}, big} >= {dm_next, {QB{1'b0}}};

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[0][l] <= {{(32 - (NW - QB)){1'b0}}, big[NW-1:QB]};
                    low_reg[0][l] <= big[QB-1:0];
                    q_reg[0][l]   <= '0;
                end
            end

            // one quotient bit per stage
            for (k = 0; k < QB; k++) begin : g_bit
                logic [32:0] rs;
                logic [32:0] rd;
                logic        ge;

                always_comb begin
                    rs = {rem_reg[k][l], low_reg[k][l][QB-1]};
                    ge = rs >= {1'b0, dm_reg[k]};
                    rd = ge ? rs - {1'b0, dm_reg[k]} : rs;
                end

                always_ff @(posedge aclk) begin
                    if (ce) begin
                        rem_reg[k+1][l] <= rd[31:0];
                        low_reg[k+1][l] <= {low_reg[k][l][QB-2:0], 1'b0};
                        q_reg[k+1][l]   <= {q_reg[k][l][QB-2:0], ge};
                    end
                end
            end

            // apply sign and saturate
            always_comb begin
                qf = q_reg[QB][l];
                if (ovf_reg[QB][l]) begin
                    x_next = neg_reg[QB][l] ? gtis_pkg::Q_MIN : gtis_pkg::Q_MAX;
                end else if (neg_reg[QB][l]) begin
                    x_next = (qf >= {{(QB-32){1'b0}}, 1'b1, 31'b0}) ? gtis_pkg::Q_MIN
                                                                   : 32'd0 - qf[31:0];
                end else begin
                    x_next = (qf >= {{(QB-32){1'b0}}, 1'b1, 31'b0}) ? gtis_pkg::Q_MAX
                                                                   : qf[31:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    x_reg[l] <= x_next;
                end
            end
        end
    endgenerate

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_x     = x_reg;
    assign out_sb    = sb_reg[NST-1];

endmodule

`default_nettype wire

// ----- rtl/gyroscopic_torque_implicit_step.sv -----
// ---------------------------------------------------------------------------
// gyroscopic_torque_implicit_step: one implicit gyroscopic Newton step
// Rotates the world velocity into the body frame, builds the residual and
// Jacobian from the configured inertia, solves one Newton update and
// rotates back, all in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry one body: orientation quaternion and
//   world angular velocity. Result beats (m_valid/m_ready) carry the new
//   velocity and the singular flag, one result per input, in order.
//   From input beat to result beat a body passes the inverse rotation, the
//   Jacobian and cofactors, the divider (one quotient bit per stage over 33
//   bits), the update register, the rotation back and the output register.
//   Every stage is a register stage.
//   Throughput is one body per cycle while s_ready is high.
//   Configuration writes (cfg_wr_en, cfg_addr, cfg_wr_data) take effect at
//   once; the user must make them while no body is in flight, as the block
//   itself does not enforce it. Reset clears all valid bits and loads the
//   default step and inertia. When the receiver stalls, the output register
//   holds its beat and one more beat lands in a skid register; the pipeline
//   then freezes and s_ready drops until the receiver takes a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module gyroscopic_torque_implicit_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wr_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  gtis_pkg::qc_t     s_orient_w,
    input  gtis_pkg::qc_t     s_orient_x,
    input  gtis_pkg::qc_t     s_orient_y,
    input  gtis_pkg::qc_t     s_orient_z,
    input  gtis_pkg::q_t      s_ang_vel_x,
    input  gtis_pkg::q_t      s_ang_vel_y,
    input  gtis_pkg::q_t      s_ang_vel_z,
    output logic              m_valid,
    input  wire logic         m_ready,
    output gtis_pkg::q_t      m_new_vel_x,
    output gtis_pkg::q_t      m_new_vel_y,
    output gtis_pkg::q_t      m_new_vel_z,
    output logic              m_singular
);

    logic [16:0]       time_step_reg;
    logic [30:0]       inertia_xx_reg, inertia_yy_reg, inertia_zz_reg;
    gtis_pkg::q_t      inertia_xy_reg, inertia_xz_reg, inertia_yz_reg;

    logic              ce;
    logic              in_acc;
    gtis_pkg::body_t   body_in;
    gtis_pkg::rvec_t   r_inv;
    gtis_pkg::vec_t    w_in;

    logic              rot1_valid;
    gtis_pkg::vec_t    rot1_v;
    gtis_pkg::body_t   rot1_body;
    gtis_pkg::jside_t  jac_in_sb;

    logic              jac_valid;
    gtis_pkg::vec_t    jac_n;
    gtis_pkg::q_t      jac_det;
    gtis_pkg::jside_t  jac_sb;
    gtis_pkg::dside_t  div_in_sb;

    logic              div_valid;
    gtis_pkg::vec_t    div_x;
    gtis_pkg::dside_t  div_sb;

    logic              upd_valid_reg;
    gtis_pkg::vec_t    vn_reg, vn_next;
    gtis_pkg::rside_t  upd_sb_reg;
    gtis_pkg::rvec_t   r_fwd;

    logic              rot2_valid;
    gtis_pkg::vec_t    rot2_o;
    gtis_pkg::rside_t  rot2_sb;

    gtis_pkg::res_t    res_next, out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg  <= 17'd1092;
            inertia_xx_reg <= 31'd65536;
            inertia_yy_reg <= 31'd65536;
            inertia_zz_reg <= 31'd65536;
            inertia_xy_reg <= '0;
            inertia_xz_reg <= '0;
            inertia_yz_reg <= '0;
        end else if (cfg_wr_en) begin
            case (gtis_pkg::cfg_idx_e'(cfg_addr))
                gtis_pkg::CFG_TIME_STEP:  time_step_reg  <= cfg_wr_data[16:0];
                gtis_pkg::CFG_INERTIA_XX: inertia_xx_reg <= cfg_wr_data[30:0];
                gtis_pkg::CFG_INERTIA_YY: inertia_yy_reg <= cfg_wr_data[30:0];
                gtis_pkg::CFG_INERTIA_ZZ: inertia_zz_reg <= cfg_wr_data[30:0];
                gtis_pkg::CFG_INERTIA_XY: inertia_xy_reg <= cfg_wr_data;
                gtis_pkg::CFG_INERTIA_XZ: inertia_xz_reg <= cfg_wr_data;
                gtis_pkg::CFG_INERTIA_YZ: inertia_yz_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline moves while the skid register is empty
    assign ce      = !skid_valid_reg;
    assign s_ready = ce;
    assign in_acc  = s_valid && ce;

    // pack the input beat, negate the vector part for the inverse rotation
    always_comb begin
        w_in         = {s_ang_vel_z, s_ang_vel_y, s_ang_vel_x};
        body_in.s    = s_orient_w;
        body_in.r    = {s_orient_z, s_orient_y, s_orient_x};
        body_in.w    = w_in;
        r_inv[0]     = -gtis_pkg::rq_t'(s_orient_x);
        r_inv[1]     = -gtis_pkg::rq_t'(s_orient_y);
        r_inv[2]     = -gtis_pkg::rq_t'(s_orient_z);
    end

    gtis_rotate #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      ($bits(gtis_pkg::body_t))
    ) u_rot_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_acc),
        .in_s      (s_orient_w),
        .in_r      (r_inv),
        .in_u      (w_in),
        .in_sb     (body_in),
        .out_valid (rot1_valid),
        .out_o     (rot1_v),
        .out_sb    (rot1_body)
    );

    always_comb begin
        jac_in_sb.body = rot1_body;
        jac_in_sb.v    = rot1_v;
    end

    gtis_jacob #(
        .FRAC_BITS  (FRAC_BITS),
        .SB_W       ($bits(gtis_pkg::jside_t))
    ) u_jacob (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .time_step  (time_step_reg),
        .inertia_xx (inertia_xx_reg),
        .inertia_yy (inertia_yy_reg),
        .inertia_zz (inertia_zz_reg),
        .inertia_xy (inertia_xy_reg),
        .inertia_xz (inertia_xz_reg),
        .inertia_yz (inertia_yz_reg),
        .in_valid   (rot1_valid),
        .in_v       (rot1_v),
        .in_sb      (jac_in_sb),
        .out_valid  (jac_valid),
        .out_n      (jac_n),
        .out_det    (jac_det),
        .out_sb     (jac_sb)
    );

    // flag a zero determinant
    always_comb begin
        div_in_sb.sing = (jac_det == '0);
        div_in_sb.body = jac_sb.body;
        div_in_sb.v    = jac_sb.v;
    end

    gtis_div #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      ($bits(gtis_pkg::dside_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (jac_valid),
        .in_n      (jac_n),
        .in_den    (jac_det),
        .in_sb     (div_in_sb),
        .out_valid (div_valid),
        .out_x     (div_x),
        .out_sb    (div_sb)
    );

    // Newton update v - inv(J) f
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vn_next[k] = gtis_pkg::sat32(gtis_pkg::acc_t'(div_sb.v[k])
                                         - gtis_pkg::acc_t'(div_x[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_valid_reg <= 1'b0;
        end else if (ce) begin
            upd_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            vn_reg          <= vn_next;
            upd_sb_reg.sing <= div_sb.sing;
            upd_sb_reg.body <= div_sb.body;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_fwd[k] = gtis_pkg::rq_t'(upd_sb_reg.body.r[k]);
        end
    end

    gtis_rotate #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      ($bits(gtis_pkg::rside_t))
    ) u_rot_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (upd_valid_reg),
        .in_s      (upd_sb_reg.body.s),
        .in_r      (r_fwd),
        .in_u      (vn_reg),
        .in_sb     (upd_sb_reg),
        .out_valid (rot2_valid),
        .out_o     (rot2_o),
        .out_sb    (rot2_sb)
    );

    // pass the velocity through when singular
    always_comb begin
        res_next.sing = rot2_sb.sing;
        res_next.v    = rot2_sb.sing ? rot2_sb.body.w : rot2_o;
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= rot2_valid;
            end
        end else if (rot2_valid && ce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= res_next;
            end
        end else if (ce) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_new_vel_x = out_reg.v[0];
    assign m_new_vel_y = out_reg.v[1];
    assign m_new_vel_z = out_reg.v[2];
    assign m_singular  = out_reg.sing;

endmodule

`default_nettype wire
